### hw/rtl/ttb_pkg.sv
// Package of the trickle timer bank: sizes, memory entry and handshake structs,
// and the random generator step function.
// It depends on nothing; every other file in hw/rtl imports it.
`default_nettype none

package ttb_pkg;

	localparam int TIMER_COUNT = 4;
	localparam int TIDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	localparam logic [31:0] REMAINING_CEILING = 32'(((64'd1 << 31) - 64'd1) / 64'd1000);
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	typedef struct packed {
		logic [31:0] base_time;
		logic [31:0] fire_time;
		logic [31:0] cur_interval;
		logic [31:0] max_interval;
	} ttb_entry_t;

	typedef struct packed {
		logic              en;
		logic [TIDX_W-1:0] addr;
		ttb_entry_t        data;
	} ttb_ram_wr_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} ttb_mod_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} ttb_mod_rsp_t;

	// One shift of the Galois generator; the result is also the drawn value.
	function automatic logic [31:0] lfsr_step(input logic [31:0] s);
		logic [31:0] n;
		n = {1'b0, s[31:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ttb_timer_ram.sv
// Timer state memory: one entry of base, fire, interval and maximum per timer.
// Synchronous write and registered read. Uses ttb_pkg.
`default_nettype none

module ttb_timer_ram
	import ttb_pkg::*;
(
	input  wire logic              clk,
	input  wire ttb_ram_wr_t       wr,
	input  wire logic              rd_en,
	input  wire logic [TIDX_W-1:0] rd_addr,
	output ttb_entry_t             rd_data
);

	ttb_entry_t mem [TIMER_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ttb_mod.sv
// Serial 32-bit remainder unit: restoring division, one quotient bit a cycle.
// The done pulse comes once all 32 quotient bits are worked through after start. Uses ttb_pkg.
`default_nettype none

module ttb_mod
	import ttb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ttb_mod_req_t req,
	output ttb_mod_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] r_q;
	logic [31:0] n_q;
	logic [31:0] d_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {r_q, n_q[31]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so 32 bits hold it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.dividend;
			d_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[30:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				r_q <= diff[31:0];
			end else begin
				r_q <= trial[31:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

`default_nettype wire

### hw/rtl/trickle_timer_bank_core.sv
// Trickle timer bank: sequencer, random generator and running marks around the
// timer memory (ttb_timer_ram) and the serial remainder unit (ttb_mod). Uses ttb_pkg.
// A start draws the base and the fire offset through the remainder unit; a tick reads every timer
// and draws a new fire time for each one that fires; every item ends with a scan of all timers.
// One item is worked on at a time; the next is taken once the result is in the output register.
// Reset clears the seed, the running marks, the generator (to 1) and the output valid.
`default_nettype none

module trickle_timer_bank_core
	import ttb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,    // seed
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,      // timer_id, now_seconds, interval_min, interval_max
	input  wire logic [1:0]   s_tuser,      // func
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata       // fired_mask, next_remaining, due_now, rejected
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_BASE    = 4'd1;
	localparam logic [3:0] ST_BASE_W  = 4'd2;
	localparam logic [3:0] ST_FDRAW   = 4'd3;
	localparam logic [3:0] ST_FIRE_W  = 4'd4;
	localparam logic [3:0] ST_WRITE   = 4'd5;
	localparam logic [3:0] ST_T_RD    = 4'd6;
	localparam logic [3:0] ST_T_EVAL  = 4'd7;
	localparam logic [3:0] ST_SC_RD   = 4'd8;
	localparam logic [3:0] ST_SC_EVAL = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	localparam logic [TIDX_W-1:0] IDX_LAST = TIDX_W'(TIMER_COUNT - 1);

	logic [3:0]             state_q;
	logic [TIDX_W-1:0]      idx_q;
	logic [15:0]            seed_q;
	logic [31:0]            lfsr_q;
	logic [31:0]            lfsr_next;
	logic [TIMER_COUNT-1:0] running_q;

	logic [1:0]  func_q;
	logic [1:0]  id_q;
	logic [31:0] now_q;
	logic [31:0] imin_q;
	logic [31:0] imax_q;

	logic [31:0] base_q;
	logic [31:0] fire_q;
	logic [31:0] cur_q;
	logic [31:0] max_q;
	logic [31:0] best_q;
	logic        rej_q;
	logic [TIMER_COUNT-1:0] fired_q;

	logic        m_valid_q;
	logic [39:0] m_data_q;

	logic [1:0]  in_func;
	logic [1:0]  in_id;
	logic [31:0] in_now;
	logic [31:0] in_imin;
	logic [31:0] in_imax;
	logic        in_id_ok;
	logic        accept;

	ttb_ram_wr_t  ram_wr;
	logic         ram_rd_en;
	ttb_entry_t   ram_rd;
	ttb_mod_req_t mod_req;
	ttb_mod_rsp_t mod_rsp;

	logic [31:0] half;
	logic [31:0] span;
	logic [31:0] off;
	logic [31:0] rd_diff;
	logic        rd_due;
	logic [32:0] dbl;
	logic        out_free;
	logic        best_due;

	assign in_func  = s_tuser;
	assign in_id    = s_tdata[1:0];
	assign in_now   = s_tdata[33:2];
	assign in_imin  = s_tdata[65:34];
	assign in_imax  = s_tdata[97:66];
	assign in_id_ok = (32'(in_id) < 32'(TIMER_COUNT));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign lfsr_next = lfsr_step(lfsr_q);

	// Second half of the interval: the random term spans cur - cur/2; an empty span adds zero.
	assign half = {1'b0, cur_q[31:1]};
	assign span = cur_q - half;
	assign off  = (span == 32'd0) ? 32'd0 : mod_rsp.rem;

	assign rd_diff = ram_rd.fire_time - now_q;
	assign rd_due  = rd_diff[31] || (rd_diff == 32'd0);
	assign dbl     = {ram_rd.cur_interval, 1'b0};

	assign ram_rd_en = (state_q == ST_T_RD) || (state_q == ST_SC_RD);

	assign ram_wr.en                = (state_q == ST_WRITE);
	assign ram_wr.addr              = idx_q;
	assign ram_wr.data.base_time    = base_q;
	assign ram_wr.data.fire_time    = fire_q;
	assign ram_wr.data.cur_interval = cur_q;
	assign ram_wr.data.max_interval = max_q;

	assign mod_req.start    = (state_q == ST_BASE) || (state_q == ST_FDRAW);
	assign mod_req.dividend = lfsr_next;
	assign mod_req.divisor  = (state_q == ST_BASE) ? imin_q : span;

	assign out_free = !m_valid_q || m_tready;
	assign best_due = best_q[31] || (best_q == 32'd0);

	ttb_timer_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd)
	);

	ttb_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			seed_q    <= '0;
			lfsr_q    <= 32'd1;
			running_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_func == FUNC_TICK) begin
							idx_q   <= '0;
							state_q <= ST_T_RD;
						end else if ((in_func == FUNC_START) && (in_imin != 32'd0)
								&& in_id_ok) begin
							lfsr_q  <= (seed_q == 16'd0) ? 32'd1 : {16'd0, seed_q};
							idx_q   <= TIDX_W'(in_id);
							state_q <= ST_BASE;
						end else begin
							idx_q   <= '0;
							state_q <= ST_SC_RD;
							if ((in_func == FUNC_STOP) && in_id_ok) begin
								running_q[TIDX_W'(in_id)] <= 1'b0;
							end
						end
					end
				end
				ST_BASE: begin
					lfsr_q  <= lfsr_next;
					state_q <= ST_BASE_W;
				end
				ST_BASE_W: begin
					if (mod_rsp.done) begin
						state_q <= ST_FDRAW;
					end
				end
				ST_FDRAW: begin
					lfsr_q  <= lfsr_next;
					state_q <= ST_FIRE_W;
				end
				ST_FIRE_W: begin
					if (mod_rsp.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (func_q == FUNC_START) begin
						running_q[TIDX_W'(id_q)] <= 1'b1;
						idx_q   <= '0;
						state_q <= ST_SC_RD;
					end else if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_SC_RD;
					end else begin
						idx_q   <= idx_q + TIDX_W'(1);
						state_q <= ST_T_RD;
					end
				end
				ST_T_RD: begin
					state_q <= ST_T_EVAL;
				end
				ST_T_EVAL: begin
					if (running_q[idx_q] && rd_due) begin
						state_q <= ST_FDRAW;
					end else if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_SC_RD;
					end else begin
						idx_q   <= idx_q + TIDX_W'(1);
						state_q <= ST_T_RD;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_EVAL;
				end
				ST_SC_EVAL: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + TIDX_W'(1);
						state_q <= ST_SC_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_func;
			id_q    <= in_id;
			now_q   <= in_now;
			imin_q  <= in_imin;
			imax_q  <= in_imax;
			best_q  <= REMAINING_CEILING;
			fired_q <= '0;
			rej_q   <= (in_func == FUNC_START) && (in_imin == 32'd0);
		end
		if ((state_q == ST_BASE_W) && mod_rsp.done) begin
			base_q <= now_q + mod_rsp.rem;
			cur_q  <= imin_q;
			max_q  <= imax_q;
		end
		if ((state_q == ST_FIRE_W) && mod_rsp.done) begin
			fire_q <= base_q + half + off;
		end
		if ((state_q == ST_T_EVAL) && running_q[idx_q] && rd_due) begin
			// The doubled interval is compared unwrapped, then capped at the maximum.
			base_q <= ram_rd.base_time + ram_rd.cur_interval;
			cur_q  <= (dbl > {1'b0, ram_rd.max_interval}) ? ram_rd.max_interval : dbl[31:0];
			max_q  <= ram_rd.max_interval;
			fired_q[idx_q] <= 1'b1;
		end
		if ((state_q == ST_SC_EVAL) && running_q[idx_q]) begin
			if ($signed(rd_diff) < $signed(best_q)) begin
				best_q <= rd_diff;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_data_q <= {2'b00, rej_q, best_due, best_q, 4'(fired_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire
